// ===== hdl/skl_pkg.sv =====
// ----------------------------------------------------------------------------
// Sorted key list package
// Shared types and constants for the sorted key list and its storage cells.
// ----------------------------------------------------------------------------
package skl_pkg;

  localparam int unsigned DefaultCapacity = 64;
  localparam int unsigned KeyWidth        = 16;
  localparam int unsigned HandleWidth     = 16;

  typedef enum logic [1:0] {
    CMD_INSERT = 2'd0,
    CMD_REMOVE = 2'd1,
    CMD_READ   = 2'd2
  } skl_cmd_e;

  typedef enum logic [2:0] {
    CELL_HOLD   = 3'd0,
    CELL_INSERT = 3'd1,
    CELL_REMOVE = 3'd2,
    CELL_LOAD   = 3'd3,
    CELL_SHIFT  = 3'd4
  } skl_cell_op_e;

  typedef struct packed {
    logic [KeyWidth-1:0]    key;
    logic [HandleWidth-1:0] handle;
  } skl_entry_t;

  typedef struct packed {
    skl_cell_op_e op;
    skl_entry_t   entry;
  } skl_ctrl_t;

endpackage

// ===== hdl/skl_cell.sv =====
// ----------------------------------------------------------------------------
// Sorted key list cell
// Holds one list entry and one read-out stage, and moves data to or from its
// neighbors on insert, remove and read-out shifts.
// ----------------------------------------------------------------------------
module skl_cell (
  input  logic               clk_i,
  input  skl_pkg::skl_ctrl_t ctrl_i,
  input  logic               occupied_i,
  input  logic               lt_prev_i,
  input  logic               after_slot_i,
  input  skl_pkg::skl_entry_t left_i,
  input  skl_pkg::skl_entry_t right_i,
  input  skl_pkg::skl_entry_t right_bus_i,
  output skl_pkg::skl_entry_t entry_o,
  output skl_pkg::skl_entry_t bus_o,
  output logic               lt_o
);

  skl_pkg::skl_entry_t entry_q, entry_d;
  skl_pkg::skl_entry_t bus_q, bus_d;

  assign lt_o = occupied_i && (entry_q.key < ctrl_i.entry.key);

  always_comb begin
    entry_d = entry_q;
    bus_d   = bus_q;
    unique case (ctrl_i.op)
      skl_pkg::CELL_HOLD: begin
      end
      skl_pkg::CELL_INSERT: begin
        if (!lt_o) begin
          entry_d = lt_prev_i ? ctrl_i.entry : left_i;
        end
      end
      skl_pkg::CELL_REMOVE: begin
        if (after_slot_i) begin
          entry_d = right_i;
        end
      end
      skl_pkg::CELL_LOAD: begin
        bus_d = entry_q;
      end
      skl_pkg::CELL_SHIFT: begin
        bus_d = right_bus_i;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
    bus_q   <= bus_d;
  end

  assign entry_o = entry_q;
  assign bus_o   = bus_q;

endmodule

// ===== hdl/skl_chain.sv =====
// ----------------------------------------------------------------------------
// Sorted key list cell row
// A row of cells that keeps the entries in ascending key order, with a
// read-out path that shifts toward the head of the row.
// ----------------------------------------------------------------------------
module skl_chain #(
  parameter int unsigned CAPACITY = skl_pkg::DefaultCapacity,
  localparam int unsigned CW = $clog2(CAPACITY + 1),
  localparam int unsigned IW = $clog2(CAPACITY)
) (
  input  logic                clk_i,
  input  skl_pkg::skl_ctrl_t  ctrl_i,
  input  logic [CW-1:0]       count_i,
  input  logic [IW-1:0]       slot_i,
  output skl_pkg::skl_entry_t head_bus_o
);

  skl_pkg::skl_entry_t entry_w [CAPACITY];
  skl_pkg::skl_entry_t bus_w   [CAPACITY];
  logic [CAPACITY-1:0] lt_w;

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    skl_pkg::skl_entry_t left_w, right_w, right_bus_w;
    logic lt_prev_w;
    logic occupied_w;
    logic after_slot_w;

    assign occupied_w   = count_i > CW'(i);
    assign after_slot_w = IW'(i) >= slot_i;

    if (i == 0) begin : g_head
      assign left_w    = '0;
      assign lt_prev_w = 1'b1;
    end else begin : g_body
      assign left_w    = entry_w[i-1];
      assign lt_prev_w = lt_w[i-1];
    end

    if (i == CAPACITY - 1) begin : g_tail
      assign right_w     = '0;
      assign right_bus_w = '0;
    end else begin : g_inner
      assign right_w     = entry_w[i+1];
      assign right_bus_w = bus_w[i+1];
    end

    skl_cell u_cell (
      .clk_i        (clk_i),
      .ctrl_i       (ctrl_i),
      .occupied_i   (occupied_w),
      .lt_prev_i    (lt_prev_w),
      .after_slot_i (after_slot_w),
      .left_i       (left_w),
      .right_i      (right_w),
      .right_bus_i  (right_bus_w),
      .entry_o      (entry_w[i]),
      .bus_o        (bus_w[i]),
      .lt_o         (lt_w[i])
    );
  end

  assign head_bus_o = bus_w[0];

endmodule

// ===== hdl/sorted_key_list_top.sv =====
// ----------------------------------------------------------------------------
// Sorted key list
// Keeps up to CAPACITY (key, handle) entries in ascending key order and
// serves insert, remove-at-position and read-at-position commands.
// ----------------------------------------------------------------------------
// The input channel carries one command word; the output channel returns one
// result word for each command: a status, the entry found by a read, and the
// entry count after the command. Both channels use valid and ready.
// An insert, a remove or a refused command completes at the accepting edge,
// so its result is valid in the next cycle. A read at position p (0 acts
// as 1) loads the read-out stages of all cells and shifts them p - 1 times
// toward the head of the row; its result is then taken from the head
// cell. Inserts and removes can follow each other in every cycle while
// results are taken, but a read holds off the next command until it is done.
// The result is held in an output register; a new command is taken while
// a result waits, as long as that result leaves in the same cycle.
// When the receiver stalls, the result stays valid and unchanged, and no
// further command is accepted. Reset empties the list at once and clears
// the output register's valid flag; stored entries are not cleared.
// ----------------------------------------------------------------------------
module sorted_key_list_top #(
  parameter int unsigned CAPACITY = skl_pkg::DefaultCapacity,
  localparam int unsigned CW = $clog2(CAPACITY + 1),
  localparam int unsigned IW = $clog2(CAPACITY)
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  logic [1:0]                      command_i,
  input  logic [skl_pkg::KeyWidth-1:0]    entry_key_i,
  input  logic [skl_pkg::HandleWidth-1:0] entry_handle_i,
  input  logic [CW-1:0]                   position_i,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output logic                            status_o,
  output logic [skl_pkg::KeyWidth-1:0]    found_key_o,
  output logic [skl_pkg::HandleWidth-1:0] found_handle_o,
  output logic [CW-1:0]                   count_o
);

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_READ = 2'b10
  } skl_state_e;

  skl_state_e state_q, state_d;
  logic [IW-1:0] cnt_q, cnt_d;
  logic [CW-1:0] count_q, count_d;
  logic out_valid_q, out_valid_d;
  logic out_status_q, out_status_d;
  skl_pkg::skl_entry_t out_entry_q, out_entry_d;
  logic [CW-1:0] out_count_q, out_count_d;

  logic accept;
  logic refused;
  logic [CW-1:0] pos_eff;
  logic [IW-1:0] slot;
  skl_pkg::skl_ctrl_t ctrl;
  skl_pkg::skl_entry_t head_bus;

  assign in_ready_o = (state_q == ST_IDLE) && (!out_valid_q || out_ready_i);
  assign accept     = in_valid_i && in_ready_o;

  assign pos_eff = (position_i == '0) ? CW'(1) : position_i;
  assign slot    = IW'(pos_eff - CW'(1));

  always_comb begin
    unique case (command_i) inside
      skl_pkg::CMD_INSERT: refused = (count_q == CW'(CAPACITY));
      skl_pkg::CMD_REMOVE,
      skl_pkg::CMD_READ:   refused = (count_q == '0) || (pos_eff > count_q);
      default:             refused = 1'b1;
    endcase
  end

  always_comb begin
    state_d      = state_q;
    cnt_d        = cnt_q;
    count_d      = count_q;
    out_valid_d  = out_valid_q && !out_ready_i;
    out_status_d = out_status_q;
    out_entry_d  = out_entry_q;
    out_count_d  = out_count_q;
    ctrl.op      = skl_pkg::CELL_HOLD;
    ctrl.entry.key    = entry_key_i;
    ctrl.entry.handle = entry_handle_i;

    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          out_status_d = refused;
          out_entry_d  = '0;
          if (refused) begin
            out_valid_d = 1'b1;
            out_count_d = count_q;
          end else begin
            unique case (command_i)
              skl_pkg::CMD_INSERT: begin
                ctrl.op     = skl_pkg::CELL_INSERT;
                count_d     = count_q + CW'(1);
                out_valid_d = 1'b1;
                out_count_d = count_d;
              end
              skl_pkg::CMD_REMOVE: begin
                ctrl.op     = skl_pkg::CELL_REMOVE;
                count_d     = count_q - CW'(1);
                out_valid_d = 1'b1;
                out_count_d = count_d;
              end
              default: begin
                ctrl.op = skl_pkg::CELL_LOAD;
                cnt_d   = slot;
                state_d = ST_READ;
              end
            endcase
          end
        end
      end
      ST_READ: begin
        if (cnt_q == '0) begin
          out_valid_d  = 1'b1;
          out_status_d = 1'b0;
          out_entry_d  = head_bus;
          out_count_d  = count_q;
          state_d      = ST_IDLE;
        end else begin
          ctrl.op = skl_pkg::CELL_SHIFT;
          cnt_d   = cnt_q - IW'(1);
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  skl_chain #(
    .CAPACITY (CAPACITY)
  ) u_chain (
    .clk_i      (clk_i),
    .ctrl_i     (ctrl),
    .count_i    (count_q),
    .slot_i     (slot),
    .head_bus_o (head_bus)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= '0;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_status_q <= out_status_d;
    out_entry_q  <= out_entry_d;
    out_count_q  <= out_count_d;
  end

  assign out_valid_o    = out_valid_q;
  assign status_o       = out_status_q;
  assign found_key_o    = out_entry_q.key;
  assign found_handle_o = out_entry_q.handle;
  assign count_o        = out_count_q;

endmodule
